// ===== rtl/core/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-512 package
// Round constants, initial hash values and helper functions for the hasher.
// ----------------------------------------------------------------------------
package sha512_pkg;

	typedef logic [63:0] word_t;

	localparam word_t RoundK [80] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

	localparam word_t InitHash [8] = '{
		64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
		64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam int LenPos = 120;
	localparam int PadLimit = 112;

	// Start and busy status between sequencer and compression unit.
	typedef struct packed {
		logic start;
		logic busy;
	} cmp_ctl_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (64 - n));
	endfunction

endpackage

// ===== rtl/core/sha512_round.sv =====
// ----------------------------------------------------------------------------
// SHA-512 compression unit
// Runs the 80 rounds of one block, one round per cycle, on one shared round
// datapath, then adds the working variables into the hash state.
// ----------------------------------------------------------------------------
module sha512_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 init_hash,
	input  sha512_pkg::word_t    block_words [16],
	output sha512_pkg::cmp_ctl_t status,
	output sha512_pkg::word_t    hash [8]
);
	import sha512_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StRun  = 2'd1;
	localparam logic [1:0] StAdd  = 2'd2;

	logic [1:0] state_q;
	logic [6:0] round_q;
	word_t      w_q [16];
	word_t      v_q [8];
	word_t      hash_q [8];

	word_t x15, x2, w_new, w_cur, s1, ch, t1, s0, maj, t2;

	// One round of the schedule and the compression.
	always_comb begin
		x15 = w_q[1];
		x2 = w_q[14];
		w_new = w_q[0] + (rotr(x15, 1) ^ rotr(x15, 8) ^ (x15 >> 7)) + w_q[9]
			+ (rotr(x2, 19) ^ rotr(x2, 61) ^ (x2 >> 6));
		w_cur = (round_q < 7'd16) ? w_q[0] : w_new;
		s1 = rotr(v_q[4], 14) ^ rotr(v_q[4], 18) ^ rotr(v_q[4], 41);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + s1 + ch + RoundK[round_q] + w_cur;
		s0 = rotr(v_q[0], 28) ^ rotr(v_q[0], 34) ^ rotr(v_q[0], 39);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = s0 + maj;
	end

	// Sequencer over the rounds; the schedule window rotates each round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			round_q <= '0;
			hash_q <= InitHash;
		end else begin
			unique case (state_q)
				StIdle: begin
					if (init_hash) begin
						hash_q <= InitHash;
					end
					if (start) begin
						state_q <= StRun;
						round_q <= '0;
					end
				end
				StRun: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'd79) begin
						state_q <= StAdd;
					end
				end
				StAdd: begin
					for (int i = 0; i < 8; i++) begin
						hash_q[i] <= hash_q[i] + v_q[i];
					end
					state_q <= StIdle;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIdle && start) begin
			w_q <= block_words;
			v_q <= hash_q;
		end else if (state_q == StRun) begin
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_cur;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	assign status.start = (state_q == StIdle) && start;
	assign status.busy = (state_q != StIdle);
	assign hash = hash_q;

endmodule

// ===== rtl/core/sha512_message_hasher.sv =====
// ----------------------------------------------------------------------------
// SHA-512 message hasher
// Streaming SHA-512 over byte-packed input transfers, with padding and digest.
// ----------------------------------------------------------------------------
// An input transfer appends its bytes to the block buffer. When the 128-byte
// block fills, one shared round datapath runs the 80 rounds, one per cycle,
// after a registered start and before a step that adds into the hash state
// and one that hands back, with stall held high throughout. Bytes of the
// filling transfer that run past the block end are written into the next block
// while the unit starts. An end-of-message transfer pads, compresses one or two
// further blocks and then offers the eight digest words most significant first,
// one per transfer; the next message is taken once the last word has been
// accepted. No new transfer is taken while a block is being compressed.
module sha512_message_hasher (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sha512_pkg::word_t message_word,
	input  logic [3:0]        byte_count,
	input  logic              end_of_message,
	output logic              out_valid,
	input  logic              out_stall,
	output sha512_pkg::word_t digest_word,
	output logic [2:0]        word_index,
	output logic              last_word
);
	import sha512_pkg::*;

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StComp  = 3'd1;
	localparam logic [2:0] StPad   = 3'd2;
	localparam logic [2:0] StFinal = 3'd3;
	localparam logic [2:0] StWait  = 3'd4;
	localparam logic [2:0] StOut   = 3'd5;

	logic [2:0]  state_q;
	word_t       buf_q [16];
	logic [6:0]  fill_q;
	logic [63:0] msg_bytes_q;
	logic        eom_q;
	logic        pending_q;
	logic        start_q;
	logic        init_q;
	logic [2:0]  idx_q;
	word_t       hold_word_q;
	logic [6:0]  hold_fill_q;
	logic [3:0]  hold_cnt_q;
	logic [3:0]  cnt;
	logic [7:0]  sum;
	logic [63:0] bits;
	word_t       hash [8];
	cmp_ctl_t    cst;
	logic        accept;
	logic        spill;
	word_t       src_word;
	logic [6:0]  src_fill;
	logic [3:0]  src_cnt;
	logic [7:0]  lane_pos [8];
	logic        lane_en [8];

	assign accept = in_valid && !in_stall;
	assign cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;
	assign sum = {1'b0, fill_q} + {4'd0, cnt};
	assign bits = msg_bytes_q << 3;

	// Byte lanes: on a transfer the bytes that fit the current block, and in the
	// first compression cycle the held bytes that ran past its end.
	assign spill = (state_q == StComp) && start_q;
	assign src_word = accept ? message_word : hold_word_q;
	assign src_fill = accept ? fill_q : hold_fill_q;
	assign src_cnt = accept ? cnt : hold_cnt_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			lane_pos[i] = {1'b0, src_fill} + 8'(i);
			lane_en[i] = (4'(i) < src_cnt) && (lane_pos[i][7] == spill);
		end
	end

	sha512_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start_q),
		.init_hash   (init_q),
		.block_words (buf_q),
		.status      (cst),
		.hash        (hash)
	);

	assign in_stall = (state_q != StIdle);
	assign out_valid = (state_q == StOut);
	assign digest_word = hash[idx_q];
	assign word_index = idx_q;
	assign last_word = (idx_q == 3'd7);

	// The accepted transfer is kept for the bytes that spill into the next block.
	always_ff @(posedge clk) begin
		if (accept) begin
			hold_word_q <= message_word;
			hold_fill_q <= fill_q;
			hold_cnt_q <= cnt;
		end
	end

	// Block buffer writes: appended bytes and padding.
	always_ff @(posedge clk) begin
		if (accept || spill) begin
			for (int i = 0; i < 8; i++) begin
				if (lane_en[i]) begin
					buf_q[lane_pos[i][6:3]][8 * (7 - lane_pos[i][2:0]) +: 8]
						<= src_word[63 - 8 * i -: 8];
				end
			end
		end else if (state_q == StPad) begin
			for (int i = 0; i < 128; i++) begin
				if (pending_q) begin
					// Extra block: only length bytes remain in use.
					if (i < LenPos) begin
						buf_q[i / 8][63 - 8 * (i % 8) -: 8] <= 8'd0;
					end else begin
						buf_q[i / 8][63 - 8 * (i % 8) -: 8] <= bits[63 - 8 * (i - LenPos) -: 8];
					end
				end else if (i == fill_q) begin
					buf_q[i / 8][63 - 8 * (i % 8) -: 8] <= PadByte;
				end else if (i > fill_q) begin
					if (i >= LenPos && fill_q < PadLimit) begin
						buf_q[i / 8][63 - 8 * (i % 8) -: 8] <= bits[63 - 8 * (i - LenPos) -: 8];
					end else begin
						buf_q[i / 8][63 - 8 * (i % 8) -: 8] <= 8'd0;
					end
				end
			end
		end
	end

	// Sequencer for appends, padding, compression and digest output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			fill_q <= '0;
			msg_bytes_q <= '0;
			eom_q <= 1'b0;
			pending_q <= 1'b0;
			start_q <= 1'b0;
			init_q <= 1'b0;
			idx_q <= '0;
		end else begin
			start_q <= 1'b0;
			init_q <= 1'b0;
			unique case (state_q)
				StIdle: begin
					if (accept) begin
						msg_bytes_q <= msg_bytes_q + {60'd0, cnt};
						eom_q <= end_of_message;
						fill_q <= sum[6:0];
						if (sum[7]) begin
							start_q <= 1'b1;
							state_q <= StComp;
						end else if (end_of_message) begin
							state_q <= StPad;
						end
					end
				end
				StComp: begin
					if (!start_q && !cst.busy) begin
						state_q <= eom_q ? StPad : StIdle;
					end
				end
				StPad: begin
					start_q <= 1'b1;
					state_q <= StFinal;
					pending_q <= !pending_q && (fill_q >= PadLimit);
				end
				StFinal: begin
					if (!start_q && !cst.busy) begin
						state_q <= pending_q ? StPad : StOut;
						idx_q <= '0;
					end
				end
				StOut: begin
					if (!out_stall) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q <= StWait;
							init_q <= 1'b1;
						end
					end
				end
				StWait: begin
					state_q <= StIdle;
					fill_q <= '0;
					msg_bytes_q <= '0;
					eom_q <= 1'b0;
				end
				default: state_q <= StIdle;
			endcase
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-512 message hasher testbench
// Streams byte-packed messages into the hasher under several idling phases and
// checks every digest word against a behavioural SHA-512 predictor.
// ----------------------------------------------------------------------------
module tb;

	import sha512_pkg::*;

	typedef struct packed {
		word_t      data;
		logic [3:0] count;
		logic       eom;
	} msg_item_t;

	typedef struct packed {
		word_t      digest;
		logic [2:0] index;
		logic       last;
	} digest_item_t;

	// Directed row: an item and, where known at a glance, the first digest word.
	typedef struct {
		msg_item_t item;
		logic      has_known;
		word_t     known_word0;
	} stim_row_t;

	localparam int WatchLimit = 20000;
	localparam int DrainCycles = 200;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	word_t      message_word;
	logic [3:0] byte_count;
	logic       end_of_message;
	logic       out_valid;
	logic       out_stall;
	word_t      digest_word;
	logic [2:0] word_index;
	logic       last_word;

	// Predictor state.
	word_t      hash_acc [8];
	logic [7:0] blk [128];
	int         blk_fill;
	logic [63:0] msg_len;

	digest_item_t digest_queue [$];
	word_t        known_queue [$];
	int   mismatches;
	bit   failed;
	int   send_idle_pct;
	int   recv_stall_pct;
	bit   hold_off;
	int   quiet_cycles;

	sha512_message_hasher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.message_word(message_word), .byte_count(byte_count),
		.end_of_message(end_of_message),
		.out_valid(out_valid), .out_stall(out_stall),
		.digest_word(digest_word), .word_index(word_index), .last_word(last_word)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic word_t ror64(word_t x, int n);
		return (x >> n) | (x << (64 - n));
	endfunction

	// One 80-round compression of the predictor's block buffer.
	task automatic compress_blk();
		word_t w [80];
		word_t v [8];
		word_t t1;
		word_t t2;
		for (int i = 0; i < 16; i++) begin
			w[i] = 0;
			for (int j = 0; j < 8; j++)
				w[i] = (w[i] << 8) | blk[i * 8 + j];
		end
		for (int i = 16; i < 80; i++)
			w[i] = w[i - 16] + w[i - 7]
				+ (ror64(w[i - 15], 1) ^ ror64(w[i - 15], 8) ^ (w[i - 15] >> 7))
				+ (ror64(w[i - 2], 19) ^ ror64(w[i - 2], 61) ^ (w[i - 2] >> 6));
		v = hash_acc;
		for (int i = 0; i < 80; i++) begin
			t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[i] + w[i];
			t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_acc[i] += v[i];
	endtask

	task automatic hash_restart();
		hash_acc = InitHash;
		blk_fill = 0;
		msg_len = 0;
	endtask

	// Predicts the digest words caused by one accepted transfer.
	task automatic predict_digest(msg_item_t it);
		int n;
		int cnt;
		logic [63:0] bits;
		digest_item_t d;
		cnt = (it.count > 8) ? 8 : it.count;
		for (int i = 0; i < cnt; i++) begin
			blk[blk_fill] = it.data[63 - 8 * i -: 8];
			blk_fill++;
			if (blk_fill == 128) begin
				compress_blk();
				blk_fill = 0;
			end
		end
		msg_len += cnt;
		if (it.eom) begin
			bits = msg_len << 3;
			n = blk_fill;
			blk[n++] = PadByte;
			if (n > PadLimit) begin
				while (n < 128) blk[n++] = 8'h00;
				compress_blk();
				n = 0;
			end
			while (n < LenPos) blk[n++] = 8'h00;
			for (int i = 0; i < 8; i++)
				blk[LenPos + i] = bits[63 - 8 * i -: 8];
			compress_blk();
			for (int i = 0; i < 8; i++) begin
				d.digest = hash_acc[i];
				d.index = i[2:0];
				d.last = (i == 7);
				digest_queue.insert(digest_queue.size(), d);
			end
			hash_restart();
		end
	endtask

	task automatic note_mismatch(string what, word_t exp_v, word_t act_v);
		failed = 1'b1;
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch %s: expected %h actual %h", what, exp_v, act_v);
	endtask

	// Offers one transfer and waits for it to be accepted; valid stays high
	// afterwards so that transfers can follow back to back.
	task automatic send_item(msg_item_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		message_word <= it.data;
		byte_count <= it.count;
		end_of_message <= it.eom;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_digest(it);
	endtask

	function automatic msg_item_t rand_item(bit allow_eom);
		msg_item_t it;
		it.data = {$urandom, $urandom};
		it.count = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'd8;
		it.eom = allow_eom && ($urandom_range(5) == 0);
		return it;
	endfunction

	task automatic wait_drained();
		while (digest_queue.size() != 0) @(posedge clk);
	endtask

	// Receiver: stalls at random, or holds off for a long stretch on request.
	always @(posedge clk) begin
		if (hold_off)
			out_stall <= 1'b1;
		else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Digest checker.
	always @(posedge clk) begin
		digest_item_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_queue.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected digest word %h", digest_word);
			end else begin
				e = digest_queue.pop_front();
				if (word_index == 3'd0 && known_queue.size() != 0) begin
					if (known_queue[0] !== 64'h0 && digest_word !== known_queue[0])
						note_mismatch("known digest", known_queue[0], digest_word);
					void'(known_queue.pop_front());
				end
				if (digest_word !== e.digest)
					note_mismatch("digest_word", e.digest, digest_word);
				if (word_index !== e.index)
					note_mismatch("word_index", word_t'(e.index), word_t'(word_index));
				if (last_word !== e.last)
					note_mismatch("last_word", word_t'(e.last), word_t'(last_word));
			end
		end
	end

	// Watchdog on cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Stimulus.
	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		msg_item_t it;
		int msgs;
		arst_n = 1'b0;
		in_valid = 1'b0;
		message_word = '0;
		byte_count = '0;
		end_of_message = 1'b0;
		out_stall = 1'b0;
		hold_off = 1'b0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatches = 0;
		failed = 1'b0;
		hash_restart();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: empty message, "abc", ignored tail bytes, oversize
		// count, padding that spills into a second block, all-ones data.
		r.has_known = 1'b1;
		r.item = '{64'h0, 4'd0, 1'b1}; r.known_word0 = 64'hcf83e1357eefb8bd;
		rows.insert(rows.size(), r);
		r.item = '{64'h616263ffffffffff, 4'd3, 1'b1}; r.known_word0 = 64'hddaf35a193617aba;
		rows.insert(rows.size(), r);
		r.has_known = 1'b0; r.known_word0 = 64'h0;
		r.item = '{64'hffffffffffffffff, 4'd15, 1'b0}; rows.insert(rows.size(), r);
		r.item = '{64'h0123456789abcdef, 4'd9, 1'b0}; rows.insert(rows.size(), r);
		for (int i = 0; i < 12; i++) begin
			r.item = '{{$urandom, $urandom}, 4'd8, 1'b0}; rows.insert(rows.size(), r);
		end
		r.item = '{64'hffffffffffffffff, 4'd5, 1'b1}; rows.insert(rows.size(), r);
		r.item = '{64'h0, 4'd8, 1'b0}; rows.insert(rows.size(), r);
		r.item = '{64'h8000000000000001, 4'd1, 1'b1}; rows.insert(rows.size(), r);
		foreach (rows[i]) begin
			if (rows[i].item.eom)
				known_queue.insert(known_queue.size(),
					rows[i].has_known ? rows[i].known_word0 : 64'h0);
			send_item(rows[i].item);
		end
		in_valid <= 1'b0;
		wait_drained();

		// Random messages in idling phases, mostly shorter than one block.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 70; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 70; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			msgs = 0;
			while (msgs < 55) begin
				it = rand_item(1'b1);
				send_item(it);
				msgs++;
			end
			it = rand_item(1'b0);
			it.eom = 1'b1;
			send_item(it);
		end

		// Long receiver hold-off while the sender keeps offering messages.
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				hold_off = 1'b1;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int m = 0; m < 3; m++) begin
				for (int i = 0; i < 4; i++) begin
					it = rand_item(1'b0);
					send_item(it);
				end
				it.eom = 1'b1;
				send_item(it);
			end
		join
		in_valid <= 1'b0;

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (!failed && digest_queue.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
